// ===== rtl/ipx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipx_pkg
// Shared types, codes and built-in default palettes of the indexed pixel
// palette expander.
// ----------------------------------------------------------------------------
package ipx_pkg;

    typedef enum logic [1:0] {
        OP_RESTORE = 2'd0,
        OP_LOAD    = 2'd1,
        OP_PIXEL   = 2'd2,
        OP_UNUSED  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        DEPTH_1BIT = 2'd0,
        DEPTH_2BIT = 2'd1,
        DEPTH_4BIT = 2'd2,
        DEPTH_8BIT = 2'd3
    } depth_t;

    typedef enum logic {
        CFG_DEPTH_CODE  = 1'b0,
        CFG_MASK_ENABLE = 1'b1
    } cfg_index_t;

    localparam logic [7:0] ALPHA_OPAQUE      = 8'hff;
    localparam logic [7:0] ALPHA_TRANSPARENT = 8'h00;

    // One pixel lookup request leaving the sequencer.
    typedef struct packed {
        logic [7:0] idx;
        logic       alpha_on;
        logic       last;
    } pixel_req_t;

    // Palette entry write.
    typedef struct packed {
        logic        en;
        logic [7:0]  idx;
        logic [23:0] color;
    } load_req_t;

    // One expanded pixel.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } rgba_t;

    localparam logic [23:0] DEF_PAL8 [256] = '{
        24'hffffff,24'hfffecb,24'hfffe9a,24'hfffe66, 24'hfffe33,24'hfefe00,24'hffcbfe,24'hffcbcb,
        24'hffcc9a,24'hffcc66,24'hffcc33,24'hfecb00, 24'hff9afe,24'hff9acc,24'hff9a9a,24'hff9966,
        24'hff9933,24'hfe9800,24'hff66fe,24'hff66cc, 24'hff6699,24'hff6666,24'hff6633,24'hfe6500,
        24'hff33fe,24'hff33cc,24'hff3399,24'hff3366, 24'hff3333,24'hfe3200,24'hfe00fe,24'hfe00cb,
        24'hfe0098,24'hfe0065,24'hfe0032,24'hfe0000, 24'hcbffff,24'hcbffcb,24'hccff9a,24'hccff66,
        24'hccff33,24'hcbfe00,24'hcbcbff,24'hcccccc, 24'hcccc99,24'hcccc66,24'hcbcb32,24'hcdcd00,
        24'hcc9aff,24'hcc99cc,24'hcc9999,24'hcc9966, 24'hcb9832,24'hcd9a00,24'hcc66ff,24'hcc66cc,
        24'hcc6699,24'hcc6666,24'hcb6532,24'hcd6600, 24'hcc33ff,24'hcb32cb,24'hcb3298,24'hcb3265,
        24'hcb3232,24'hcd3300,24'hcb00fe,24'hcd00cd, 24'hcd009a,24'hcd0066,24'hcd0033,24'hcd0000,
        24'h9affff,24'h9affcc,24'h9aff9a,24'h99ff66, 24'h99ff33,24'h99fe00,24'h9accff,24'h99cccc,
        24'h009865,24'h99cc66,24'h99cb32,24'h9acd00, 24'h9a9aff,24'h9999cc,24'h999999,24'h989865,
        24'h9a9a33,24'h989800,24'h9966ff,24'h9966cc, 24'h986598,24'h986565,24'h9a6633,24'h986500,
        24'h9933ff,24'h9832cb,24'h9a339a,24'h9a3366, 24'h9a3333,24'h983200,24'h9800fe,24'h9a00cd,
        24'h980098,24'h980065,24'h980032,24'h980000, 24'h66ffff,24'h66ffcc,24'h66ff99,24'h66ff66,
        24'h66ff33,24'h66fe00,24'h66ccff,24'h66cccc, 24'h66cc99,24'h66cc66,24'h66cb32,24'h66cd00,
        24'h6699ff,24'h6699cc,24'h659898,24'h659865, 24'h669a33,24'h659800,24'h6666ff,24'h6666cc,
        24'h656598,24'h666666,24'h656532,24'h666600, 24'h6633ff,24'h6532cb,24'h66339a,24'h653265,
        24'h653232,24'h663300,24'h6500fe,24'h6600cd, 24'h650098,24'h660066,24'h660033,24'h660000,
        24'h33ffff,24'h33ffcc,24'h33ff99,24'h33ff66, 24'h33ff33,24'h33fe00,24'h33ccff,24'h32cbcb,
        24'h32cb98,24'h32cb65,24'h33cb32,24'h33cd00, 24'h3399ff,24'h3299cb,24'h339a9a,24'h339a66,
        24'h339a33,24'h329800,24'h3366ff,24'h3266cb, 24'h33669a,24'h326565,24'h326532,24'h336600,
        24'h3333ff,24'h3233cb,24'h33339a,24'h323265, 24'h333333,24'h333300,24'h3200fe,24'h3300cd,
        24'h320098,24'h330066,24'h330033,24'h330000, 24'h00fefe,24'h00fecb,24'h00fe98,24'h00fe65,
        24'h00fe32,24'h00fe00,24'h00cbfe,24'h00cdcd, 24'h00cd9a,24'h00cd66,24'h00cd33,24'h00cd00,
        24'h0098fe,24'h009acd,24'h009898,24'h009865, 24'h009832,24'h009800,24'h0066fe,24'h0066cd,
        24'h006598,24'h006666,24'h006633,24'h006600, 24'h0033fe,24'h0033cd,24'h003298,24'h003366,
        24'h003333,24'h003300,24'h0000fe,24'h0000cd, 24'h000098,24'h000066,24'h000033,24'hef0000,
        24'hdc0000,24'hba0000,24'hab0000,24'h890000, 24'h770000,24'h550000,24'h440000,24'h220000,
        24'h110000,24'h00ef00,24'h00dc00,24'h00ba00, 24'h00ab00,24'h008900,24'h007700,24'h005500,
        24'h004400,24'h002200,24'h001100,24'h0000ef, 24'h0000dc,24'h0000ba,24'h0000ab,24'h000089,
        24'h000077,24'h000055,24'h000044,24'h000022, 24'h000011,24'heeeeee,24'hdddddd,24'hbbbbbb,
        24'haaaaaa,24'h888888,24'h777777,24'h555555, 24'h444444,24'h222222,24'h111111,24'h000000
    };

    localparam logic [23:0] DEF_PAL4 [16] = '{
        24'hffffff,24'hffff00,24'hffa07a,24'hff0000, 24'hff1493,24'h8a2be2,24'h000080,24'h6495ed,
        24'h228b22,24'h006400,24'h8b4513,24'hd2b48c, 24'hd3d3d3,24'hbebebe,24'h696969,24'h000000
    };

    localparam logic [23:0] DEF_PAL2 [4] = '{24'hffffff, 24'hffff00, 24'h00ffff, 24'h000000};

    localparam logic [23:0] DEF_PAL1 [2] = '{24'hffffff, 24'h000000};

    // Built-in colour of an index at the given depth.
    function automatic logic [23:0] default_color(input depth_t depth, input logic [7:0] idx);
        logic [23:0] c;
        unique case (depth)
            DEPTH_1BIT: c = DEF_PAL1[idx[0]];
            DEPTH_2BIT: c = DEF_PAL2[idx[1:0]];
            DEPTH_4BIT: c = DEF_PAL4[idx[3:0]];
            default:    c = DEF_PAL8[idx];
        endcase
        return c;
    endfunction

    // Keeps only the index bits that exist at the given depth.
    function automatic logic [7:0] mask_index(input depth_t depth, input logic [7:0] idx);
        logic [7:0] m;
        unique case (depth)
            DEPTH_1BIT: m = {7'd0, idx[0]};
            DEPTH_2BIT: m = {6'd0, idx[1:0]};
            DEPTH_4BIT: m = {4'd0, idx[3:0]};
            default:    m = idx;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/ipx_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipx_seq
// Pixel sequencer: holds a packed byte, one lookup per cycle while can_issue.
// ----------------------------------------------------------------------------
module ipx_seq
    import ipx_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       start,
    input  logic [7:0] pixel_byte,
    input  logic [7:0] mask_bits,
    input  logic [3:0] pixel_count,
    input  depth_t     depth,
    input  logic       mask_enable,
    input  logic       can_issue,
    output logic       accept_ok,
    output logic       issue_valid,
    output pixel_req_t issue_req
);

    logic       busy_reg,  busy_next;
    logic [7:0] byte_reg,  byte_next;
    logic [7:0] mask_reg,  mask_next;
    logic [3:0] count_reg, count_next;

    logic       fire;
    logic       is_last;
    logic [3:0] cap;
    logic [3:0] eff_count;
    logic [7:0] cur_idx;
    logic [7:0] shifted_byte;

    always_comb begin
        unique case (depth)
            DEPTH_1BIT: begin
                cap          = 4'd8;
                cur_idx      = {7'd0, byte_reg[7]};
                shifted_byte = {byte_reg[6:0], 1'b0};
            end
            DEPTH_2BIT: begin
                cap          = 4'd4;
                cur_idx      = {6'd0, byte_reg[7:6]};
                shifted_byte = {byte_reg[5:0], 2'b00};
            end
            DEPTH_4BIT: begin
                cap          = 4'd2;
                cur_idx      = {4'd0, byte_reg[7:4]};
                shifted_byte = {byte_reg[3:0], 4'h0};
            end
            default: begin
                cap          = 4'd1;
                cur_idx      = byte_reg;
                shifted_byte = 8'd0;
            end
        endcase
    end

    assign eff_count = (pixel_count > cap) ? cap : pixel_count;
    assign fire      = busy_reg && can_issue;
    assign is_last   = (count_reg == 4'd1);
    assign accept_ok = !busy_reg || (fire && is_last);

    assign issue_valid        = fire;
    assign issue_req.idx      = cur_idx;
    assign issue_req.alpha_on = !mask_enable || mask_reg[7];
    assign issue_req.last     = is_last;

    always_comb begin
        busy_next  = busy_reg;
        byte_next  = byte_reg;
        mask_next  = mask_reg;
        count_next = count_reg;
        if (start && (eff_count != 4'd0)) begin
            busy_next  = 1'b1;
            byte_next  = pixel_byte;
            mask_next  = mask_bits;
            count_next = eff_count;
        end else if (fire) begin
            busy_next  = !is_last;
            byte_next  = shifted_byte;
            mask_next  = {mask_reg[6:0], 1'b0};
            count_next = count_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            count_reg <= 4'd0;
        end else begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        mask_reg <= mask_next;
    end

endmodule

// ===== rtl/ipx_clut.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipx_clut
// Colour table: override flags, loaded-colour memory and default palettes.
// ----------------------------------------------------------------------------
module ipx_clut
    import ipx_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  depth_t     depth,
    input  logic       clear_all,
    input  load_req_t  load,
    input  logic       issue_valid,
    input  pixel_req_t issue_req,
    output logic       res_valid,
    output rgba_t      res
);

    localparam int AW = $clog2(PALETTE_ENTRIES);

    logic [23:0]                color_mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] flag_reg, flag_next;

    logic [23:0] rd_data_reg;
    logic        s1_valid_reg;
    logic [7:0]  s1_idx_reg;
    logic        s1_flag_reg;
    logic        s1_alpha_reg;
    logic        s1_last_reg;

    logic          load_in_range;
    logic          rd_in_range;
    logic [AW-1:0] load_addr;
    logic [AW-1:0] rd_addr;
    logic          rd_flag;
    logic [23:0]   color;

    assign load_in_range = ({1'b0, load.idx} < 9'(PALETTE_ENTRIES));
    assign rd_in_range   = ({1'b0, issue_req.idx} < 9'(PALETTE_ENTRIES));
    assign load_addr     = load.idx[AW-1:0];
    assign rd_addr       = issue_req.idx[AW-1:0];
    assign rd_flag       = rd_in_range && flag_reg[rd_addr];

    always_comb begin
        flag_next = flag_reg;
        if (clear_all) begin
            flag_next = '0;
        end else if (load.en && load_in_range) begin
            flag_next[load_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            flag_reg     <= flag_next;
            s1_valid_reg <= issue_valid;
        end
    end

    // Memory port: one write, one registered read.
    always_ff @(posedge aclk) begin
        if (load.en && load_in_range) begin
            color_mem[load_addr] <= load.color;
        end
        if (issue_valid && rd_in_range) begin
            rd_data_reg <= color_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (issue_valid) begin
            s1_idx_reg   <= issue_req.idx;
            s1_flag_reg  <= rd_flag;
            s1_alpha_reg <= issue_req.alpha_on;
            s1_last_reg  <= issue_req.last;
        end
    end

    assign color     = s1_flag_reg ? rd_data_reg : default_color(depth, s1_idx_reg);
    assign res_valid = s1_valid_reg;
    assign res.red   = color[23:16];
    assign res.green = color[15:8];
    assign res.blue  = color[7:0];
    assign res.alpha = s1_alpha_reg ? ALPHA_OPAQUE : ALPHA_TRANSPARENT;
    assign res.last  = s1_last_reg;

endmodule

// ===== rtl/ipx_out_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipx_out_fifo
// Two-entry result queue that decouples the lookup pipeline from the output.
// ----------------------------------------------------------------------------
module ipx_out_fifo
    import ipx_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  rgba_t push_data,
    input  logic  pop,
    output logic  not_empty,
    output rgba_t head
);

    rgba_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;

    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/indexed_pixel_palette_expander.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_pixel_palette_expander
// Expands packed 1/2/4/8-bit indexed pixels into RGBA through a colour table
// that lies over built-in default palettes.
// ----------------------------------------------------------------------------
// The block produces one RGBA result beat per cycle unless the output stalls.
// A pixel-byte beat with n valid pixels (n capped at 8 divided by the depth
// in bits) holds the pixel sequencer for n lookups, so a 1-bit byte gives
// eight lookups and an 8-bit byte one; restore and load beats give no result.
// The next input beat is taken in the cycle the last pixel of the current
// byte is issued, so results stream without gaps. The pace is set by the
// single read port of the colour memory, which serves one pixel per cycle.
// A pixel reaches the output through the memory read register and then the
// two-entry output queue. The override flags sit in flip-flops and are
// cleared at once by reset or by a restore beat; there is no clearing pass.
// Configuration must be written while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module indexed_pixel_palette_expander
    import ipx_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic       aclk,
    input  logic       aresetn,

    // Configuration write port.
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [1:0] cfg_wr_data,

    // Input channel.
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_operation,
    input  logic [7:0] s_entry_index,
    input  logic [7:0] s_entry_red,
    input  logic [7:0] s_entry_green,
    input  logic [7:0] s_entry_blue,
    input  logic [7:0] s_pixel_byte,
    input  logic [7:0] s_mask_bits,
    input  logic [3:0] s_pixel_count,

    // Result channel.
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_red,
    output logic [7:0] m_green,
    output logic [7:0] m_blue,
    output logic [7:0] m_alpha,
    output logic       m_last_pixel
);

    // Configuration registers.
    depth_t depth_code_reg,  depth_code_next;
    logic   mask_enable_reg, mask_enable_next;

    // Lookups in flight plus results queued; never exceeds the queue depth.
    logic [1:0] occ_reg, occ_next;

    logic       in_beat;
    op_t        op;
    logic       accept_ok;
    logic       can_issue;
    logic       issue_valid;
    pixel_req_t issue_req;
    load_req_t  load;
    logic       clear_all;
    logic       res_valid;
    rgba_t      res;
    rgba_t      head;
    logic       pop;

    assign op      = op_t'(s_operation);
    assign s_ready = accept_ok;
    assign in_beat = s_valid && s_ready;

    always_comb begin
        depth_code_next  = depth_code_reg;
        mask_enable_next = mask_enable_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DEPTH_CODE:  depth_code_next  = depth_t'(cfg_wr_data);
                CFG_MASK_ENABLE: mask_enable_next = cfg_wr_data[0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_code_reg  <= DEPTH_8BIT;
            mask_enable_reg <= 1'b0;
            occ_reg         <= 2'd0;
        end else begin
            depth_code_reg  <= depth_code_next;
            mask_enable_reg <= mask_enable_next;
            occ_reg         <= occ_next;
        end
    end

    // A new lookup may issue while there is room for its result, counting a
    // slot that the output frees in the same cycle.
    assign pop       = m_valid && m_ready;
    assign can_issue = (occ_reg != 2'd2) || pop;
    assign occ_next  = occ_reg + {1'b0, issue_valid} - {1'b0, pop};

    // Restore and load act as the beat is taken; pixel lookups issued
    // earlier in the same cycle still see the old table.
    assign clear_all  = in_beat && (op == OP_RESTORE);
    assign load.en    = in_beat && (op == OP_LOAD);
    assign load.idx   = mask_index(depth_code_reg, s_entry_index);
    assign load.color = {s_entry_red, s_entry_green, s_entry_blue};

    ipx_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (in_beat && (op == OP_PIXEL)),
        .pixel_byte  (s_pixel_byte),
        .mask_bits   (s_mask_bits),
        .pixel_count (s_pixel_count),
        .depth       (depth_code_reg),
        .mask_enable (mask_enable_reg),
        .can_issue   (can_issue),
        .accept_ok   (accept_ok),
        .issue_valid (issue_valid),
        .issue_req   (issue_req)
    );

    ipx_clut #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_clut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .depth       (depth_code_reg),
        .clear_all   (clear_all),
        .load        (load),
        .issue_valid (issue_valid),
        .issue_req   (issue_req),
        .res_valid   (res_valid),
        .res         (res)
    );

    ipx_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .pop       (pop),
        .not_empty (m_valid),
        .head      (head)
    );

    assign m_red        = head.red;
    assign m_green      = head.green;
    assign m_blue       = head.blue;
    assign m_alpha      = head.alpha;
    assign m_last_pixel = head.last;

endmodule

// ===== verif/indexed_pixel_palette_expander_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_pixel_palette_expander_tb
// Self-checking testbench for the indexed pixel palette expander. A directed
// walk through the edge cases comes first. Random phases follow, each at its
// own pixel depth and alpha setting. Every result beat is compared with a
// pixel owed by the testbench's colour-table predictor or the directed walk.
// ----------------------------------------------------------------------------
module indexed_pixel_palette_expander_tb;
    import ipx_pkg::*;

    localparam int ENTRIES      = 256;
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_BEATS  = 30;
    // The idle tail covers a load or restore that is still in flight.
    localparam int IDLE_TAIL    = 8;
    localparam int LONG_HOLD    = 300;
    localparam int TIMEOUT_NS   = 2_000_000;

    // One input beat, with the fields in the order the ports take them.
    typedef struct packed {
        op_t        op;
        logic [7:0] idx;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] pix;
        logic [7:0] mask;
        logic [3:0] count;
    } beat_t;

    typedef enum logic {
        ROW_BEAT,
        ROW_REG
    } row_kind_t;

    // A directed row is either a register write or an input beat. Where the
    // single result of a beat is plain to see, it is typed in as known_px.
    typedef struct packed {
        row_kind_t  kind;
        cfg_index_t reg_sel;
        logic [1:0] reg_value;
        beat_t      beat;
        logic       known;
        rgba_t      known_px;
    } row_t;

    localparam beat_t NO_BEAT   = '0;
    localparam rgba_t NO_PX     = '0;
    localparam rgba_t WHITE_PX  = '{8'hff, 8'hff, 8'hff, ALPHA_OPAQUE, 1'b1};
    localparam rgba_t BLACK_PX  = '{8'h00, 8'h00, 8'h00, ALPHA_OPAQUE, 1'b1};
    localparam rgba_t CLEAR_PX  = '{8'hff, 8'hff, 8'hff, ALPHA_TRANSPARENT, 1'b1};

    localparam int N_ROWS = 31;

    // Directed walk. The block starts at 8-bit depth with alpha masking off.
    localparam row_t directed_rows [N_ROWS] = '{
        // Index extremes straight after reset.
        '{ROW_BEAT, CFG_DEPTH_CODE, 2'd0,
          '{OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'd1}, 1'b1, WHITE_PX},
        '{ROW_BEAT, CFG_DEPTH_CODE, 2'd0,
          '{OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'h00, 4'd1}, 1'b1, BLACK_PX},
        // Count far above the cap is cut to one pixel at 8-bit depth.
        '{ROW_BEAT, CFG_DEPTH_CODE, 2'd0,
          '{OP_PIXEL, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'hff, 4'd15}, 1'b1, WHITE_PX},
        // A count of zero and the unused operation give nothing at all.
        '{ROW_BEAT, CFG_DEPTH_CODE, 2'd0,
          '{OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'ha5, 8'hff, 4'd0}, 1'b0, NO_PX},
        '{ROW_BEAT, CFG_DEPTH_CODE, 2'd0,
          '{OP_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 4'd15}, 1'b0, NO_PX},
        // Overrides at both ends of the table.
        '{ROW_BEAT, CFG_DEPTH_CODE, 2'd0,
          '{OP_LOAD, 8'h00, 8'h12, 8'h34, 8'h56, 8'h00, 8'h00, 4'd0}, 1'b0, NO_PX},
        '{ROW_BEAT, CFG_DEPTH_CODE, 2'd0,
          '{OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'd1},
          1'b1, '{8'h12, 8'h34, 8'h56, ALPHA_OPAQUE, 1'b1}},
        '{ROW_BEAT, CFG_DEPTH_CODE, 2'd0,
          '{OP_LOAD, 8'hff, 8'hff, 8'h00, 8'hff, 8'h00, 8'h00, 4'd0}, 1'b0, NO_PX},
        '{ROW_BEAT, CFG_DEPTH_CODE, 2'd0,
          '{OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'h00, 4'd1},
          1'b1, '{8'hff, 8'h00, 8'hff, ALPHA_OPAQUE, 1'b1}},
        // Restore brings the built-in colours back.
        '{ROW_BEAT, CFG_DEPTH_CODE, 2'd0,
          '{OP_RESTORE, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 4'd15}, 1'b0, NO_PX},
        '{ROW_BEAT, CFG_DEPTH_CODE, 2'd0,
          '{OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'd1}, 1'b1, WHITE_PX},
        // Alpha from the mask bits.
        '{ROW_REG, CFG_MASK_ENABLE, 2'd1, NO_BEAT, 1'b0, NO_PX},
        '{ROW_BEAT, CFG_DEPTH_CODE, 2'd0,
          '{OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'd1}, 1'b1, CLEAR_PX},
        '{ROW_BEAT, CFG_DEPTH_CODE, 2'd0,
          '{OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'h80, 4'd1}, 1'b1, BLACK_PX},
        '{ROW_BEAT, CFG_DEPTH_CODE, 2'd0,
          '{OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37, 8'h7f, 4'd8}, 1'b0, NO_PX},
        // 1-bit depth: the load index is masked down to entry 0.
        '{ROW_REG, CFG_DEPTH_CODE, DEPTH_1BIT, NO_BEAT, 1'b0, NO_PX},
        '{ROW_BEAT, CFG_DEPTH_CODE, 2'd0,
          '{OP_LOAD, 8'hfe, 8'h0a, 8'h0b, 8'h0c, 8'h00, 8'h00, 4'd0}, 1'b0, NO_PX},
        '{ROW_BEAT, CFG_DEPTH_CODE, 2'd0,
          '{OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5a, 8'ha5, 4'd8}, 1'b0, NO_PX},
        '{ROW_BEAT, CFG_DEPTH_CODE, 2'd0,
          '{OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 4'd9}, 1'b0, NO_PX},
        // 2-bit depth: the override on entry 0 stays in place.
        '{ROW_REG, CFG_DEPTH_CODE, DEPTH_2BIT, NO_BEAT, 1'b0, NO_PX},
        '{ROW_BEAT, CFG_DEPTH_CODE, 2'd0,
          '{OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'he4, 8'h3c, 4'd4}, 1'b0, NO_PX},
        '{ROW_BEAT, CFG_DEPTH_CODE, 2'd0,
          '{OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1b, 8'hc3, 4'd5}, 1'b0, NO_PX},
        // 4-bit depth with masking off again.
        '{ROW_REG, CFG_DEPTH_CODE, DEPTH_4BIT, NO_BEAT, 1'b0, NO_PX},
        '{ROW_REG, CFG_MASK_ENABLE, 2'd0, NO_BEAT, 1'b0, NO_PX},
        '{ROW_BEAT, CFG_DEPTH_CODE, 2'd0,
          '{OP_LOAD, 8'h3f, 8'h80, 8'h40, 8'h20, 8'h00, 8'h00, 4'd0}, 1'b0, NO_PX},
        '{ROW_BEAT, CFG_DEPTH_CODE, 2'd0,
          '{OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'hf0, 8'h00, 4'd2}, 1'b0, NO_PX},
        '{ROW_BEAT, CFG_DEPTH_CODE, 2'd0,
          '{OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0f, 8'h00, 4'd3}, 1'b0, NO_PX},
        // Back at 8 bits the override made at 4 bits still shows on entry 15.
        '{ROW_REG, CFG_DEPTH_CODE, DEPTH_8BIT, NO_BEAT, 1'b0, NO_PX},
        '{ROW_BEAT, CFG_DEPTH_CODE, 2'd0,
          '{OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0f, 8'h00, 4'd1},
          1'b1, '{8'h80, 8'h40, 8'h20, ALPHA_OPAQUE, 1'b1}},
        '{ROW_BEAT, CFG_DEPTH_CODE, 2'd0,
          '{OP_RESTORE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'd0}, 1'b0, NO_PX},
        '{ROW_BEAT, CFG_DEPTH_CODE, 2'd0,
          '{OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0f, 8'h00, 4'd1}, 1'b0, NO_PX}
    };

    // ------------------------------------------------------------------------
    // Block inputs, all known from time zero.
    // ------------------------------------------------------------------------
    logic       aclk;
    logic       aresetn       = 1'b0;
    logic       cfg_wr_en     = 1'b0;
    logic       cfg_index     = 1'b0;
    logic [1:0] cfg_wr_data   = 2'd0;
    logic       s_valid       = 1'b0;
    logic [1:0] s_operation   = 2'd0;
    logic [7:0] s_entry_index = 8'd0;
    logic [7:0] s_entry_red   = 8'd0;
    logic [7:0] s_entry_green = 8'd0;
    logic [7:0] s_entry_blue  = 8'd0;
    logic [7:0] s_pixel_byte  = 8'd0;
    logic [7:0] s_mask_bits   = 8'd0;
    logic [3:0] s_pixel_count = 4'd0;
    logic       m_ready       = 1'b0;

    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_red;
    logic [7:0] m_green;
    logic [7:0] m_blue;
    logic [7:0] m_alpha;
    logic       m_last_pixel;

    // ------------------------------------------------------------------------
    // Colour-table predictor state. Its own copy of the registers, the
    // override flags and the loaded colours.
    // ------------------------------------------------------------------------
    depth_t      cur_depth   = DEPTH_8BIT;
    logic        cur_mask_en = 1'b0;
    logic        held        [ENTRIES];
    logic [23:0] palette_ram [ENTRIES];

    rgba_t       predicted[$];       // pixels of the beat just predicted
    rgba_t       pending_pixels[$];  // pixels still owed by the block

    int          error_count   = 0;
    bit          in_burst      = 1'b0;
    bit          out_burst     = 1'b0;
    bit          hold_request  = 1'b0;

    indexed_pixel_palette_expander #(
        .PALETTE_ENTRIES(ENTRIES)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_entry_index (s_entry_index),
        .s_entry_red   (s_entry_red),
        .s_entry_green (s_entry_green),
        .s_entry_blue  (s_entry_blue),
        .s_pixel_byte  (s_pixel_byte),
        .s_mask_bits   (s_mask_bits),
        .s_pixel_count (s_pixel_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_alpha       (m_alpha),
        .m_last_pixel  (m_last_pixel)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // A hard stop, well beyond the slowest legal run.
    initial begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor.
    // ------------------------------------------------------------------------

    // The colour an index takes when no override lies over it, at the
    // current depth.
    function automatic logic [23:0] builtin_rgb(input logic [7:0] idx);
        logic [23:0] rgb;
        case (cur_depth)
            DEPTH_1BIT: rgb = DEF_PAL1[idx[0]];
            DEPTH_2BIT: rgb = DEF_PAL2[idx[1:0]];
            DEPTH_4BIT: rgb = DEF_PAL4[idx[3:0]];
            default:    rgb = DEF_PAL8[idx];
        endcase
        return rgb;
    endfunction

    // Applies one accepted beat to the predictor state and leaves the pixels
    // it should produce in predicted.
    function automatic void expand_beat(input beat_t b);
        int unsigned bits;
        int unsigned cap;
        int unsigned n;
        int unsigned k;
        logic [7:0]  idx_mask;
        logic [7:0]  idx;
        logic [23:0] rgb;
        rgba_t       px;
        predicted.delete();
        bits     = 1 << cur_depth;
        idx_mask = 8'((1 << bits) - 1);
        case (b.op)
            OP_RESTORE: begin
                foreach (held[e]) held[e] = 1'b0;
            end
            OP_LOAD: begin
                idx = b.idx & idx_mask;
                if (idx < ENTRIES) begin
                    palette_ram[idx] = {b.red, b.green, b.blue};
                    held[idx]        = 1'b1;
                end
            end
            OP_PIXEL: begin
                cap = 8 / bits;
                n   = (b.count > cap) ? cap : b.count;
                for (k = 0; k < n; k++) begin
                    // Pixels are packed from the most significant end.
                    idx = (b.pix >> (8 - bits * (k + 1))) & idx_mask;
                    rgb = (idx < ENTRIES && held[idx]) ? palette_ram[idx] : builtin_rgb(idx);
                    px.red   = rgb[23:16];
                    px.green = rgb[15:8];
                    px.blue  = rgb[7:0];
                    px.alpha = (cur_mask_en && !b.mask[7 - k]) ? ALPHA_TRANSPARENT
                                                               : ALPHA_OPAQUE;
                    px.last  = (k == n - 1);
                    predicted.push_back(px);
                end
            end
            default: begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------------

    // Offers one beat after a random gap and waits for the block to take it.
    // s_valid is left high afterwards, so back-to-back beats never see it
    // lowered and raised again in the same step.
    task automatic send_beat(input beat_t b, input logic known, input rgba_t known_px);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= b.op;
        s_entry_index <= b.idx;
        s_entry_red   <= b.red;
        s_entry_green <= b.green;
        s_entry_blue  <= b.blue;
        s_pixel_byte  <= b.pix;
        s_mask_bits   <= b.mask;
        s_pixel_count <= b.count;
        do @(posedge aclk); while (!s_ready);
        expand_beat(b);
        if (known) begin
            pending_pixels.push_back(known_px);
        end else begin
            foreach (predicted[i]) pending_pixels.push_back(predicted[i]);
        end
    endtask

    // Stops offering and waits until every owed pixel has come out.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
    endtask

    // As above, then lets a load or restore that gives no pixel finish too,
    // so that a register can be written safely.
    task automatic settle_idle();
        drain_results();
        repeat (IDLE_TAIL) @(posedge aclk);
    endtask

    // One register write. The trailing wait keeps two writes in a row from
    // touching the write enable twice in one step.
    task automatic write_reg(input cfg_index_t sel, input logic [1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= sel;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        if (sel == CFG_DEPTH_CODE) cur_depth = depth_t'(value);
        else                       cur_mask_en = value[0];
        @(posedge aclk);
    endtask

    // Mostly pixel beats with a count the depth allows, a fair share of
    // loads, and now and then a restore, a stray operation or a wild count.
    function automatic beat_t random_beat();
        beat_t       b;
        int unsigned roll;
        int unsigned cap;
        roll    = $urandom_range(0, 99);
        cap     = 8 >> cur_depth;
        b.op    = (roll < 6)  ? OP_RESTORE :
                  (roll < 32) ? OP_LOAD    :
                  (roll < 95) ? OP_PIXEL   : OP_UNUSED;
        b.idx   = 8'($urandom);
        b.red   = 8'($urandom);
        b.green = 8'($urandom);
        b.blue  = 8'($urandom);
        b.pix   = 8'($urandom);
        b.mask  = 8'($urandom);
        b.count = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(1, cap));
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // Result side. The sink draws a wait before every beat; a long hold can be
    // requested once, during which the block has to back up into its input.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            gap = out_burst ? 0 : $urandom_range(0, 15);
            if (hold_request) begin
                gap          = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Compares each accepted result beat with the oldest owed pixel.
    always @(posedge aclk) begin
        rgba_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("result beat with nothing owed: rgba %h%h%h%h last %b",
                       m_red, m_green, m_blue, m_alpha, m_last_pixel);
                error_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (m_red !== want.red) begin
                    $error("red: expected %h, got %h", want.red, m_red);
                    error_count++;
                end
                if (m_green !== want.green) begin
                    $error("green: expected %h, got %h", want.green, m_green);
                    error_count++;
                end
                if (m_blue !== want.blue) begin
                    $error("blue: expected %h, got %h", want.blue, m_blue);
                    error_count++;
                end
                if (m_alpha !== want.alpha) begin
                    $error("alpha: expected %h, got %h", want.alpha, m_alpha);
                    error_count++;
                end
                if (m_last_pixel !== want.last) begin
                    $error("last_pixel: expected %b, got %b", want.last, m_last_pixel);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, the directed walk, then the random phases.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        beat_t      b;
        depth_t     depth;
        logic [1:0] mask_on;
        int         taken;
        foreach (held[e]) held[e] = 1'b0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG) begin
                settle_idle();
                write_reg(directed_rows[i].reg_sel, directed_rows[i].reg_value);
            end else begin
                send_beat(directed_rows[i].beat, directed_rows[i].known,
                          directed_rows[i].known_px);
            end
        end

        // The first four phases visit every depth with both alpha settings
        // among them; the rest pick their setting at random.
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle_idle();
            depth   = (p < 4) ? depth_t'(p) : depth_t'($urandom_range(0, 3));
            mask_on = (p < 4) ? 2'(p[0] ^ p[1]) : 2'($urandom_range(0, 1));
            write_reg(CFG_DEPTH_CODE, depth);
            write_reg(CFG_MASK_ENABLE, mask_on);

            in_burst  = (p == 2) || ($urandom_range(0, 3) == 0);
            out_burst = (p == 2) || ($urandom_range(0, 3) == 0);
            // One phase stalls the result side for a long while, with the
            // input side pushing as hard as the block lets it.
            if (p == 5) begin
                in_burst     = 1'b1;
                hold_request = 1'b1;
            end

            taken = 0;
            while (taken < PHASE_BEATS) begin
                // Halfway through one phase the sender waits for the block
                // to empty completely before carrying on.
                if (p == 3 && taken == PHASE_BEATS / 2) drain_results();
                b = random_beat();
                send_beat(b, 1'b0, NO_PX);
                if (b.op != OP_UNUSED) taken++;
            end
        end

        settle_idle();
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
